// File: src/trht_pkg.sv
// ----------------------------------------------------------------------------
// trht_pkg
// Shared types and constants for the topmost rectangle hit test block.
// ----------------------------------------------------------------------------
package trht_pkg;

  // Command codes carried by the input channel
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Field widths fixed by the interface
  localparam int COORD_W  = 20;
  localparam int SLOT_W   = 8;
  localparam int STRATA_W = 4;
  localparam int LEVEL_W  = 16;
  localparam int KEY_W    = STRATA_W + LEVEL_W;

  // Largest number of slots an 8-bit slot field can address
  localparam int SLOT_SPAN = 1 << SLOT_W;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // One stored rectangle entry (everything except the hittable flag)
  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] bottom;
    logic signed [COORD_W-1:0] width;
    logic signed [COORD_W-1:0] height;
    logic [STRATA_W-1:0]       strata;
    logic [LEVEL_W-1:0]        level;
  } entry_t;

  // One classified operation handed from front to back
  typedef struct packed {
    logic                      cmd;
    logic [SLOT_W-1:0]         slot;
    logic                      hittable;
    entry_t                    entry;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } op_t;

endpackage

// File: src/trht_ram.sv
// ----------------------------------------------------------------------------
// trht_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module trht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/trht_front.sv
// ----------------------------------------------------------------------------
// trht_front
// Accepts input transfers, drops writes to slot zero or beyond the table,
// and packs the rest into operations for the queue.
// ----------------------------------------------------------------------------
module trht_front
  import trht_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_cmd,
  input  logic [SLOT_W-1:0]         in_slot,
  input  logic                      in_hittable,
  input  logic signed [COORD_W-1:0] in_edge_left,
  input  logic signed [COORD_W-1:0] in_edge_bottom,
  input  logic signed [COORD_W-1:0] in_rect_width,
  input  logic signed [COORD_W-1:0] in_rect_height,
  input  logic [STRATA_W-1:0]       in_strata_rank,
  input  logic [LEVEL_W-1:0]        in_frame_level,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic                      q_full,
  output logic                      q_push,
  output op_t                       q_op
);

  logic slot_ok;
  logic keep;

  // A write only counts when it names a real, nonzero slot
  assign slot_ok = (in_slot != '0) && (int'(in_slot) < TABLE_DEPTH);
  assign keep    = (in_cmd == CMD_QUERY) || slot_ok;

  // Accept whenever the queue has room; dropped writes still transfer
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

  // Pack the operation
  always_comb begin
    q_op              = '0;
    q_op.cmd          = in_cmd;
    q_op.slot         = in_slot;
    q_op.hittable     = in_hittable;
    q_op.entry.left   = in_edge_left;
    q_op.entry.bottom = in_edge_bottom;
    q_op.entry.width  = in_rect_width;
    q_op.entry.height = in_rect_height;
    q_op.entry.strata = in_strata_rank;
    q_op.entry.level  = in_frame_level;
    q_op.px           = in_point_x;
    q_op.py           = in_point_y;
  end

endmodule

// File: src/trht_queue.sv
// ----------------------------------------------------------------------------
// trht_queue
// Short FIFO of operations between the front and the back.
// ----------------------------------------------------------------------------
module trht_queue
  import trht_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  op_t              slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// File: src/trht_back.sv
// ----------------------------------------------------------------------------
// trht_back
// Executes operations: writes table entries, and for a query scans every
// entry from slot 1 up through a three-stage read/test/select pipeline,
// then presents the winner in the output register.
// ----------------------------------------------------------------------------
module trht_back
  import trht_pkg::*;
#(
  parameter int NUM_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  op_t               q_op,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SLOT_W-1:0] out_hit_slot,
  output logic              out_hit_found
);

  localparam int AW = $clog2(NUM_ENTRIES);
  localparam logic [AW-1:0] IDX_FIRST = AW'(1);
  localparam logic [AW-1:0] IDX_LAST  = AW'(NUM_ENTRIES - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_PUSH  = 2'd3;

  logic [1:0]                state_r, state_nxt;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic signed [COORD_W-1:0] px_r, px_nxt;
  logic signed [COORD_W-1:0] py_r, py_nxt;
  logic [NUM_ENTRIES-1:0]    hitv_r;
  logic                      hitv_we;

  // Pipeline stages
  logic                      s1_r, s1_nxt;
  logic [AW-1:0]             s1_idx_r;
  logic                      s1_hv_r;
  logic                      s2_r;
  logic                      c_hit_r;
  logic [KEY_W-1:0]          c_key_r;
  logic [AW-1:0]             c_idx_r;
  logic                      found_r, found_nxt;
  logic [KEY_W-1:0]          best_key_r, best_key_nxt;
  logic [AW-1:0]             best_idx_r, best_idx_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]         out_slot_r, out_slot_nxt;
  logic                      out_found_r, out_found_nxt;

  logic                      ram_we;
  logic [AW-1:0]             ram_addr;
  entry_t                    ram_rdata;

  logic signed [COORD_W:0]   right_edge, top_edge;
  logic signed [COORD_W:0]   x_ext, y_ext, l_ext, b_ext;
  logic                      contains;

  trht_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (q_op.entry),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = idx_r;
    hitv_we       = 1'b0;
    s1_nxt        = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_slot_nxt  = out_slot_r;
    out_found_nxt = out_found_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_op.cmd == CMD_WRITE) begin
            ram_we   = 1'b1;
            ram_addr = q_op.slot[AW-1:0];
            hitv_we  = 1'b1;
          end else begin
            px_nxt    = q_op.px;
            py_nxt    = q_op.py;
            idx_nxt   = IDX_FIRST;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        s1_nxt  = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_r && !s2_r) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = SLOT_W'(best_idx_r);
          out_found_nxt = found_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Containment test on the entry read last cycle (sums at 21 bits)
  assign x_ext      = {px_r[COORD_W-1], px_r};
  assign y_ext      = {py_r[COORD_W-1], py_r};
  assign l_ext      = {ram_rdata.left[COORD_W-1], ram_rdata.left};
  assign b_ext      = {ram_rdata.bottom[COORD_W-1], ram_rdata.bottom};
  assign right_edge = l_ext + {ram_rdata.width[COORD_W-1], ram_rdata.width};
  assign top_edge   = b_ext + {ram_rdata.height[COORD_W-1], ram_rdata.height};
  assign contains   = s1_hv_r
                   && (ram_rdata.width > 0) && (ram_rdata.height > 0)
                   && (x_ext >= l_ext) && (x_ext <= right_edge)
                   && (y_ext >= b_ext) && (y_ext <= top_edge);

  // Running best; a new query clears it, later equal keys win
  always_comb begin
    found_nxt    = found_r;
    best_key_nxt = best_key_r;
    best_idx_nxt = best_idx_r;
    if (state_r == ST_IDLE) begin
      found_nxt    = 1'b0;
      best_key_nxt = '0;
      best_idx_nxt = '0;
    end else if (s2_r && c_hit_r && (!found_r || (c_key_r >= best_key_r))) begin
      found_nxt    = 1'b1;
      best_key_nxt = c_key_r;
      best_idx_nxt = c_idx_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_r        <= 1'b0;
      s2_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      hitv_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      s1_r        <= s1_nxt;
      s2_r        <= s1_r;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (hitv_we) begin
        hitv_r[ram_addr] <= q_op.hittable;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    s1_idx_r    <= idx_r;
    s1_hv_r     <= hitv_r[idx_r];
    c_hit_r     <= contains;
    c_key_r     <= {ram_rdata.strata, ram_rdata.level};
    c_idx_r     <= s1_idx_r;
    best_key_r  <= best_key_nxt;
    best_idx_r  <= best_idx_nxt;
    out_slot_r  <= out_slot_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_hit_slot  = out_slot_r;
  assign out_hit_found = out_found_r;

endmodule

// File: src/topmost_rect_hit_test.sv
// ----------------------------------------------------------------------------
// topmost_rect_hit_test
// Table of rectangles; a query returns the topmost hittable entry that
// contains a point (strata, then level, then slot decide).
//
//   channel | ports              | direction | transfer when
//   --------+--------------------+-----------+-------------------------
//   input   | in_valid, in_*     | in        | in_valid && !in_stall
//   result  | out_valid, out_*   | out       | out_valid && !out_stall
//
// A write is done in the back in the same cycle it leaves the queue.
// A query holds the back while it is taken from the queue, one read of
// the single-port entry memory is made per slot from 1 up, the test/select
// pipeline drains and the output register is loaded; only then does the
// back take the next operation from the queue.
// The front keeps accepting into a two-entry queue while the back works.
// Reset clears the hittable flags of all entries at once; other entry
// fields are undefined until written.
// A stalled result holds in the output register; the back waits for it.
// ----------------------------------------------------------------------------
module topmost_rect_hit_test
  import trht_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_cmd,
  input  logic [SLOT_W-1:0]         in_slot,
  input  logic                      in_hittable,
  input  logic signed [COORD_W-1:0] in_edge_left,
  input  logic signed [COORD_W-1:0] in_edge_bottom,
  input  logic signed [COORD_W-1:0] in_rect_width,
  input  logic signed [COORD_W-1:0] in_rect_height,
  input  logic [STRATA_W-1:0]       in_strata_rank,
  input  logic [LEVEL_W-1:0]        in_frame_level,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [SLOT_W-1:0]         out_hit_slot,
  output logic                      out_hit_found
);

  // Slots past what the slot field can name are never written
  localparam int NUM_ENTRIES = (TABLE_DEPTH < SLOT_SPAN) ? TABLE_DEPTH : SLOT_SPAN;

  logic q_push, q_full, q_pop, q_valid;
  op_t  push_op, head_op;

  trht_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_slot        (in_slot),
    .in_hittable    (in_hittable),
    .in_edge_left   (in_edge_left),
    .in_edge_bottom (in_edge_bottom),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_strata_rank (in_strata_rank),
    .in_frame_level (in_frame_level),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_op           (push_op)
  );

  trht_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_op    (head_op)
  );

  trht_back #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_op          (head_op),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit_slot  (out_hit_slot),
    .out_hit_found (out_hit_found)
  );

`ifndef NO_ASSERTIONS
  // A miss always reports slot zero
  a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit_found) |-> (out_hit_slot == '0))
    else $error("miss reported with nonzero slot");

  // A hit never names slot zero
  a_hit_slot_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit_found) |-> (out_hit_slot != '0))
    else $error("hit reported on slot zero");

  // Reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
